[rtl/spqws_pkg.sv]
// ----------------------------------------------------------------------------
// spqws_pkg
// Shared types and constants of the strict priority queue wait statistics
// block: field widths, command codes, time limits and the wait result record.
// ----------------------------------------------------------------------------
package spqws_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int CLASS_W     = 2;
	localparam int CMD_W       = 2;
	localparam int HOUR_W      = 5;
	localparam int MINUTE_W    = 6;
	localparam int STAMP_W     = HOUR_W + MINUTE_W;
	localparam int OCCUPANCY_W = 5;
	localparam int SERVED_W    = 16;
	localparam int PEAK_W      = 7;
	localparam int WAIT_W      = 11;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SERVE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	localparam logic [HOUR_W-1:0]   HOUR_MAX         = 5'd23;
	localparam logic [MINUTE_W-1:0] MINUTE_MAX       = 6'd59;
	localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = 6'd60;
	localparam logic [HOUR_W-1:0]   HOURS_PER_DAY    = 5'd24;

	typedef struct packed {
		logic [HOUR_W-1:0]   hours;
		logic [MINUTE_W-1:0] minutes;
		logic [WAIT_W-1:0]   total;
	} wait_t;

endpackage

[rtl/spqws_wait_calc.sv]
// ----------------------------------------------------------------------------
// spqws_wait_calc
// Elapsed time between an arrival stamp and a service time, with a borrow at
// one hour and a wrap at one day, plus the same wait in whole minutes.
// ----------------------------------------------------------------------------
module spqws_wait_calc (
	input  logic [spqws_pkg::HOUR_W-1:0]   hour,
	input  logic [spqws_pkg::MINUTE_W-1:0] minute,
	input  logic [spqws_pkg::STAMP_W-1:0]  stamp,
	output spqws_pkg::wait_t               result
);
	import spqws_pkg::*;

	logic [MINUTE_W:0]   dm_raw;
	logic                borrow;
	logic [HOUR_W:0]     dh_raw;
	logic [MINUTE_W-1:0] minutes;
	logic [HOUR_W-1:0]   hours;

	assign dm_raw = {1'b0, minute} - {1'b0, stamp[MINUTE_W-1:0]};
	assign borrow = dm_raw[MINUTE_W];
	// Adding 60 modulo 64 restores a negative difference to 0..59.
	assign minutes = borrow ? (dm_raw[MINUTE_W-1:0] + MINUTES_PER_HOUR)
	                        : dm_raw[MINUTE_W-1:0];

	assign dh_raw = {1'b0, hour} - {1'b0, stamp[STAMP_W-1:MINUTE_W]}
	              - {{HOUR_W{1'b0}}, borrow};
	assign hours = dh_raw[HOUR_W] ? (dh_raw[HOUR_W-1:0] + HOURS_PER_DAY)
	                              : dh_raw[HOUR_W-1:0];

	assign result.hours   = hours;
	assign result.minutes = minutes;
	assign result.total   = WAIT_W'(hours) * WAIT_W'(MINUTES_PER_HOUR) + WAIT_W'(minutes);

endmodule

[rtl/strict_priority_queue_wait_stats_core.sv]
// ----------------------------------------------------------------------------
// strict_priority_queue_wait_stats_core
// Four strict priority FIFO queues of arrival stamps with wait statistics.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on in_valid/in_ready with cmd, priority_class, hour and
// minute. Arrive pushes a stamp into the named class, serve pops the head of
// the non-empty class of highest priority (class 0 is highest) and reports
// its wait, query only reports. Every item yields exactly one result item
// on out_valid/out_ready. The item is taken into the work stage, and the
// result goes into the output register when that register is free.
// The work stage holds one item at a time: on accept the selected queue
// head is read from the single-port stamp memory into a register; the
// work stage then computes the update and loads the result register.
// in_ready stays high while a result waits in the output register, so one
// further item may be taken; it then holds in the work stage until the
// receiver takes the pending result.
// Reset clears all counts, pointers and statistics at once; the stamp
// memory needs no clearing since only written entries are ever used.
// ----------------------------------------------------------------------------
module strict_priority_queue_wait_stats_core #(
	parameter int QUEUE_DEPTH = spqws_pkg::DEF_QUEUE_DEPTH,
	parameter int COUNT_WIDTH = spqws_pkg::DEF_COUNT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [spqws_pkg::CMD_W-1:0]       cmd,
	input  logic [spqws_pkg::CLASS_W-1:0]     priority_class,
	input  logic [spqws_pkg::HOUR_W-1:0]      hour,
	input  logic [spqws_pkg::MINUTE_W-1:0]    minute,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              served,
	output logic [spqws_pkg::CLASS_W-1:0]     served_class,
	output logic [spqws_pkg::HOUR_W-1:0]      wait_hours,
	output logic [spqws_pkg::MINUTE_W-1:0]    wait_minutes,
	output logic                              dropped,
	output logic [spqws_pkg::OCCUPANCY_W-1:0] class_occupancy,
	output logic [spqws_pkg::SERVED_W-1:0]    class_served,
	output logic [spqws_pkg::SERVED_W-1:0]    total_served,
	output logic [spqws_pkg::PEAK_W-1:0]      peak_occupancy,
	output logic [spqws_pkg::WAIT_W-1:0]      max_wait
);
	import spqws_pkg::*;

	localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int TOT_W     = $clog2(MEM_DEPTH + 1);
	localparam int OCC_PAD_W = OCC_W + OCCUPANCY_W;
	localparam int CNT_PAD_W = COUNT_WIDTH + SERVED_W;
	localparam int TOT_PAD_W = TOT_W + PEAK_W;

	// Queue state.
	logic [PTR_W-1:0]       head_q   [NUM_CLASSES];
	logic [OCC_W-1:0]       count_q  [NUM_CLASSES];
	logic [COUNT_WIDTH-1:0] scount_q [NUM_CLASSES];
	logic [COUNT_WIDTH-1:0] stotal_q;
	logic [TOT_W-1:0]       peak_q;
	logic [WAIT_W-1:0]      longest_q;

	logic [PTR_W-1:0]       head_d   [NUM_CLASSES];
	logic [OCC_W-1:0]       count_d  [NUM_CLASSES];
	logic [COUNT_WIDTH-1:0] scount_d [NUM_CLASSES];
	logic [COUNT_WIDTH-1:0] stotal_d;
	logic [TOT_W-1:0]       peak_d;
	logic [WAIT_W-1:0]      longest_d;

	logic [STAMP_W-1:0] mem [MEM_DEPTH];

	// Work stage.
	logic                valid_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [CLASS_W-1:0]  cls_s1;
	logic [HOUR_W-1:0]   hour_s1;
	logic [MINUTE_W-1:0] minute_s1;
	logic [CLASS_W-1:0]  sel_s1;
	logic                avail_s1;
	logic [STAMP_W-1:0]  stamp_s1;

	// Output register.
	logic                   out_valid_q;
	logic                   served_q;
	logic [CLASS_W-1:0]     served_class_q;
	logic [HOUR_W-1:0]      wait_hours_q;
	logic [MINUTE_W-1:0]    wait_minutes_q;
	logic                   dropped_q;
	logic [OCCUPANCY_W-1:0] class_occupancy_q;
	logic [SERVED_W-1:0]    class_served_q;
	logic [SERVED_W-1:0]    total_served_q;
	logic [PEAK_W-1:0]      peak_occupancy_q;
	logic [WAIT_W-1:0]      max_wait_q;

	logic                accept;
	logic                complete;
	logic [CLASS_W-1:0]  sel_cls;
	logic                sel_avail;
	logic [ADDR_W-1:0]   rd_addr;
	logic [HOUR_W-1:0]   hour_sat;
	logic [MINUTE_W-1:0] minute_sat;

	logic [PTR_W:0]      tail_sum;
	logic [PTR_W-1:0]    tail;
	logic [ADDR_W-1:0]   wr_addr;
	logic                wr_en;
	logic [TOT_W-1:0]    new_total;
	logic                full;
	wait_t               wait_res;

	logic                   res_served;
	logic                   res_dropped;
	logic [OCC_PAD_W-1:0]   occ_pad;
	logic [CNT_PAD_W-1:0]   cls_cnt_pad;
	logic [CNT_PAD_W-1:0]   tot_cnt_pad;
	logic [TOT_PAD_W-1:0]   peak_pad;

	assign in_ready = !valid_s1;
	assign accept   = in_valid && in_ready;
	assign complete = valid_s1 && (!out_valid_q || out_ready);

	assign hour_sat   = (hour > HOUR_MAX) ? HOUR_MAX : hour;
	assign minute_sat = (minute > MINUTE_MAX) ? MINUTE_MAX : minute;

	// Highest priority class with an entry waiting.
	always_comb begin
		sel_cls   = '0;
		sel_avail = 1'b0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (count_q[c] != '0) begin
				sel_cls   = CLASS_W'(c);
				sel_avail = 1'b1;
			end
		end
	end

	assign rd_addr = ADDR_W'(ADDR_W'(sel_cls) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(head_q[sel_cls]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (complete) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd;
			cls_s1    <= priority_class;
			hour_s1   <= hour_sat;
			minute_s1 <= minute_sat;
			sel_s1    <= sel_cls;
			avail_s1  <= sel_avail;
		end
	end

	// Stamp memory: read at accept, written when an arrival completes.
	always_ff @(posedge clk) begin
		if (accept) begin
			stamp_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= {hour_s1, minute_s1};
		end
	end

	spqws_wait_calc u_wait (
		.hour   (hour_s1),
		.minute (minute_s1),
		.stamp  (stamp_s1),
		.result (wait_res)
	);

	assign full      = (count_q[cls_s1] == OCC_W'(QUEUE_DEPTH));
	assign tail_sum  = (PTR_W+1)'(head_q[cls_s1]) + (PTR_W+1)'(count_q[cls_s1]);
	assign tail      = (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH))
	                 ? PTR_W'(tail_sum - (PTR_W+1)'(QUEUE_DEPTH)) : tail_sum[PTR_W-1:0];
	assign wr_addr   = ADDR_W'(ADDR_W'(cls_s1) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(tail);
	assign new_total = TOT_W'(count_q[0]) + TOT_W'(count_q[1]) + TOT_W'(count_q[2])
	                 + TOT_W'(count_q[3]) + TOT_W'(1);

	always_comb begin
		head_d      = head_q;
		count_d     = count_q;
		scount_d    = scount_q;
		stotal_d    = stotal_q;
		peak_d      = peak_q;
		longest_d   = longest_q;
		wr_en       = 1'b0;
		res_served  = 1'b0;
		res_dropped = 1'b0;
		unique case (cmd_s1)
			CMD_ARRIVE: begin
				if (full) begin
					res_dropped = 1'b1;
				end else begin
					wr_en           = complete;
					count_d[cls_s1] = count_q[cls_s1] + OCC_W'(1);
					if (new_total > peak_q) begin
						peak_d = new_total;
					end
				end
			end
			CMD_SERVE: begin
				if (avail_s1) begin
					res_served      = 1'b1;
					count_d[sel_s1] = count_q[sel_s1] - OCC_W'(1);
					head_d[sel_s1]  = (head_q[sel_s1] == PTR_W'(QUEUE_DEPTH - 1))
					                ? '0 : head_q[sel_s1] + PTR_W'(1);
					if (scount_q[sel_s1] != '1) begin
						scount_d[sel_s1] = scount_q[sel_s1] + COUNT_WIDTH'(1);
					end
					if (stotal_q != '1) begin
						stotal_d = stotal_q + COUNT_WIDTH'(1);
					end
					if (wait_res.total > longest_q) begin
						longest_d = wait_res.total;
					end
				end
			end
			CMD_QUERY: begin
			end
			default: begin
			end
		endcase
		occ_pad     = OCC_PAD_W'(count_d[cls_s1]);
		cls_cnt_pad = CNT_PAD_W'(scount_d[cls_s1]);
		tot_cnt_pad = CNT_PAD_W'(stotal_d);
		peak_pad    = TOT_PAD_W'(peak_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c]   <= '0;
				count_q[c]  <= '0;
				scount_q[c] <= '0;
			end
			stotal_q  <= '0;
			peak_q    <= '0;
			longest_q <= '0;
		end else if (complete) begin
			head_q    <= head_d;
			count_q   <= count_d;
			scount_q  <= scount_d;
			stotal_q  <= stotal_d;
			peak_q    <= peak_d;
			longest_q <= longest_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (complete) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			served_q          <= res_served;
			served_class_q    <= res_served ? sel_s1 : '0;
			wait_hours_q      <= res_served ? wait_res.hours : '0;
			wait_minutes_q    <= res_served ? wait_res.minutes : '0;
			dropped_q         <= res_dropped;
			class_occupancy_q <= occ_pad[OCCUPANCY_W-1:0];
			class_served_q    <= cls_cnt_pad[SERVED_W-1:0];
			total_served_q    <= tot_cnt_pad[SERVED_W-1:0];
			peak_occupancy_q  <= peak_pad[PEAK_W-1:0];
			max_wait_q        <= longest_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign served          = served_q;
	assign served_class    = served_class_q;
	assign wait_hours      = wait_hours_q;
	assign wait_minutes    = wait_minutes_q;
	assign dropped         = dropped_q;
	assign class_occupancy = class_occupancy_q;
	assign class_served    = class_served_q;
	assign total_served    = total_served_q;
	assign peak_occupancy  = peak_occupancy_q;
	assign max_wait        = max_wait_q;

endmodule

[rtl/spqws_checker.sv]
// ----------------------------------------------------------------------------
// spqws_checker
// Port-level checks of the strict priority queue wait statistics block.
// ----------------------------------------------------------------------------
module spqws_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              served,
	input logic [spqws_pkg::CLASS_W-1:0]     served_class,
	input logic [spqws_pkg::HOUR_W-1:0]      wait_hours,
	input logic [spqws_pkg::MINUTE_W-1:0]    wait_minutes,
	input logic                              dropped,
	input logic [spqws_pkg::SERVED_W-1:0]    total_served,
	input logic [spqws_pkg::WAIT_W-1:0]      max_wait
);
	import spqws_pkg::*;

	logic [WAIT_W-1:0] wait_total;

	assign wait_total = WAIT_W'(wait_hours) * WAIT_W'(MINUTES_PER_HOUR) + WAIT_W'(wait_minutes);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_served) && $stable(max_wait))
		else $error("result changed while stalled");

	// The work stage takes one item at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while previous item still in work");

	a_serve_or_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(served && dropped))
		else $error("result both served and dropped");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !served |-> served_class == '0 && wait_hours == '0 && wait_minutes == '0)
		else $error("serve fields set without a served entry");

	a_max_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && served |-> wait_total <= max_wait && total_served != '0)
		else $error("served wait exceeds longest wait");

endmodule

bind strict_priority_queue_wait_stats_core spqws_checker u_spqws_checker (.*);

[bench/strict_priority_queue_wait_stats_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strict_priority_queue_wait_stats_core_tb
// Self-checking bench for the four-class priority queue with wait statistics.
// A queue of pending items feeds a clocked driver. The driver sends them in
// random bursts, and it can hold until all results are in. A scoreboard
// predicts each result from its own copy of the queues and counters. The
// monitor compares every result with the oldest prediction while the
// receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module strict_priority_queue_wait_stats_core_tb;

	import spqws_pkg::*;

	localparam int QDEPTH       = DEF_QUEUE_DEPTH;
	localparam int PTR_W        = $clog2(DEF_QUEUE_DEPTH);
	localparam int RANDOM_ITEMS = 950;
	localparam int REPORT_LIMIT = 10;
	localparam int LONG_HOLD    = 250;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [CLASS_W-1:0]  pclass;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic                drain_first;
	} request_t;

	typedef struct packed {
		logic                   served;
		logic [CLASS_W-1:0]     served_class;
		logic [HOUR_W-1:0]      wait_hours;
		logic [MINUTE_W-1:0]    wait_minutes;
		logic                   dropped;
		logic [OCCUPANCY_W-1:0] class_occupancy;
		logic [SERVED_W-1:0]    class_served;
		logic [SERVED_W-1:0]    total_served;
		logic [PEAK_W-1:0]      peak_occupancy;
		logic [WAIT_W-1:0]      max_wait;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [CMD_W-1:0]       cmd = '0;
	logic [CLASS_W-1:0]     priority_class = '0;
	logic [HOUR_W-1:0]      hour = '0;
	logic [MINUTE_W-1:0]    minute = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   served;
	logic [CLASS_W-1:0]     served_class;
	logic [HOUR_W-1:0]      wait_hours;
	logic [MINUTE_W-1:0]    wait_minutes;
	logic                   dropped;
	logic [OCCUPANCY_W-1:0] class_occupancy;
	logic [SERVED_W-1:0]    class_served;
	logic [SERVED_W-1:0]    total_served;
	logic [PEAK_W-1:0]      peak_occupancy;
	logic [WAIT_W-1:0]      max_wait;

	strict_priority_queue_wait_stats_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.priority_class  (priority_class),
		.hour            (hour),
		.minute          (minute),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.served          (served),
		.served_class    (served_class),
		.wait_hours      (wait_hours),
		.wait_minutes    (wait_minutes),
		.dropped         (dropped),
		.class_occupancy (class_occupancy),
		.class_served    (class_served),
		.total_served    (total_served),
		.peak_occupancy  (peak_occupancy),
		.max_wait        (max_wait)
	);

	// Scoreboard copy of the queues and statistics.
	logic [STAMP_W-1:0]     stamp_mem [NUM_CLASSES][QDEPTH];
	logic [PTR_W-1:0]       head_ptr [NUM_CLASSES];
	logic [OCCUPANCY_W-1:0] occ [NUM_CLASSES];
	logic [SERVED_W-1:0]    served_cnt [NUM_CLASSES];
	logic [SERVED_W-1:0]    served_sum;
	logic [PEAK_W-1:0]      peak_seen;
	logic [WAIT_W-1:0]      longest_seen;

	request_t pending_items [$];
	report_t  report_fifo [$];
	request_t cur_item;

	int items_taken = 0;
	int results_seen = 0;
	int fail_count = 0;
	int n_dropped = 0;
	int n_served = 0;
	int n_empty_serves = 0;
	int n_drains = 0;
	int holds_done = 0;
	int gap_left = 0;
	int burst_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic report_t next_report(input request_t r);
		report_t             rep;
		logic [HOUR_W-1:0]   hr;
		logic [MINUTE_W-1:0] mn;
		logic [STAMP_W-1:0]  stamp;
		int                  cls;
		int                  sel;
		int                  c;
		int                  total;
		int                  dh;
		int                  dm;
		int                  w;
		rep = '0;
		hr = (r.hour > HOUR_MAX) ? HOUR_MAX : r.hour;
		mn = (r.minute > MINUTE_MAX) ? MINUTE_MAX : r.minute;
		cls = r.pclass;
		if (r.cmd == CMD_ARRIVE) begin
			if (occ[cls] >= QDEPTH) begin
				rep.dropped = 1'b1;
				n_dropped++;
			end else begin
				stamp_mem[cls][(int'(head_ptr[cls]) + int'(occ[cls])) % QDEPTH] = {hr, mn};
				occ[cls]++;
				total = 0;
				for (c = 0; c < NUM_CLASSES; c++)
					total += occ[c];
				if (total > peak_seen)
					peak_seen = total[PEAK_W-1:0];
			end
		end else if (r.cmd == CMD_SERVE) begin
			sel = -1;
			for (c = NUM_CLASSES - 1; c >= 0; c--)
				if (occ[c] != 0)
					sel = c;
			if (sel < 0) begin
				n_empty_serves++;
			end else begin
				stamp = stamp_mem[sel][head_ptr[sel]];
				dh = int'(hr) - int'(stamp[STAMP_W-1:MINUTE_W]);
				dm = int'(mn) - int'(stamp[MINUTE_W-1:0]);
				// Borrow an hour for negative minutes, then wrap into one day.
				if (dm < 0) begin
					dm += int'(MINUTES_PER_HOUR);
					dh -= 1;
				end
				if (dh < 0)
					dh += int'(HOURS_PER_DAY);
				w = dh * int'(MINUTES_PER_HOUR) + dm;
				if (w > longest_seen)
					longest_seen = w[WAIT_W-1:0];
				head_ptr[sel] = head_ptr[sel] + 1'b1;
				occ[sel]--;
				if (served_cnt[sel] != '1)
					served_cnt[sel]++;
				if (served_sum != '1)
					served_sum++;
				n_served++;
				rep.served = 1'b1;
				rep.served_class = sel[CLASS_W-1:0];
				rep.wait_hours = dh[HOUR_W-1:0];
				rep.wait_minutes = dm[MINUTE_W-1:0];
			end
		end
		rep.class_occupancy = occ[cls];
		rep.class_served = served_cnt[cls];
		rep.total_served = served_sum;
		rep.peak_occupancy = peak_seen;
		rep.max_wait = longest_seen;
		return rep;
	endfunction

	function automatic string report_text(input report_t r);
		return $sformatf("served=%0d class=%0d wait=%0d:%0d dropped=%0d occ=%0d csrv=%0d tsrv=%0d peak=%0d maxw=%0d",
			r.served, r.served_class, r.wait_hours, r.wait_minutes, r.dropped,
			r.class_occupancy, r.class_served, r.total_served, r.peak_occupancy,
			r.max_wait);
	endfunction

	task automatic push_item(input logic [CMD_W-1:0] c, input int cls, input int hr, input int mn);
		request_t r;
		r.cmd = c;
		r.pclass = cls[CLASS_W-1:0];
		r.hour = hr[HOUR_W-1:0];
		r.minute = mn[MINUTE_W-1:0];
		r.drain_first = 1'b0;
		pending_items.push_back(r);
	endtask

	task automatic push_drain();
		request_t r;
		r = '0;
		r.drain_first = 1'b1;
		pending_items.push_back(r);
	endtask

	// Mostly legal clock times, now and then an out-of-range value.
	function automatic int rand_hour();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
	endfunction

	function automatic int rand_minute();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
	endfunction

	// Driver: takes items from the pending queue in bursts separated by gaps.
	always @(posedge clk or negedge arst_n) begin
		bit offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= '0;
			priority_class <= '0;
			hour <= '0;
			minute <= '0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				report_fifo.push_back(next_report(cur_item));
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				offer = 1'b0;
				if (pending_items.size() != 0 && pending_items[0].drain_first) begin
					// Hold the input until every outstanding result has come back.
					if (report_fifo.size() == 0) begin
						void'(pending_items.pop_front());
						n_drains++;
					end
				end else if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					cmd <= cur_item.cmd;
					priority_class <= cur_item.pclass;
					hour <= cur_item.hour;
					minute <= cur_item.minute;
					offer = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						if ($urandom_range(0, 3) == 0)
							gap_left = 0;
						else
							gap_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 25 : 4);
					end
				end
				in_valid <= offer;
			end
		end
	end

	// Receiver: changing stall patterns plus two long hold-offs.
	always @(posedge clk or negedge arst_n) begin
		int mode;
		int mode_left;
		int hold_left;
		if (!arst_n) begin
			out_ready <= 1'b0;
			mode = 0;
			mode_left = 0;
			hold_left = 0;
		end else begin
			if (hold_left == 0 && holds_done < 2 && results_seen >= (holds_done + 1) * 300) begin
				hold_left = LONG_HOLD;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end else begin
					mode_left--;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 9) < 3);
					default: out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// Monitor: every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			got.served = served;
			got.served_class = served_class;
			got.wait_hours = wait_hours;
			got.wait_minutes = wait_minutes;
			got.dropped = dropped;
			got.class_occupancy = class_occupancy;
			got.class_served = class_served;
			got.total_served = total_served;
			got.peak_occupancy = peak_occupancy;
			got.max_wait = max_wait;
			results_seen++;
			if (report_fifo.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("[%0t] result with nothing expected: %s", $time, report_text(got));
			end else begin
				want = report_fifo.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("[%0t] mismatch on result %0d", $time, results_seen);
						$display("    expected %s", report_text(want));
						$display("    actual   %s", report_text(got));
					end
				end
			end
		end
	end

	initial begin
		int c;
		int n;
		int k;
		int seg;
		int cls;
		int random_count;
		int spin;

		for (c = 0; c < NUM_CLASSES; c++) begin
			head_ptr[c] = '0;
			occ[c] = '0;
			served_cnt[c] = '0;
		end
		served_sum = '0;
		peak_seen = '0;
		longest_seen = '0;

		// Directed part: empty state, unused command, time extremes, borrow and wrap.
		for (c = 0; c < NUM_CLASSES; c++)
			push_item(CMD_QUERY, c, 0, 0);
		push_item(CMD_SERVE, 2, 7, 7);
		push_item(CMD_UNUSED, 1, 31, 63);
		push_item(CMD_ARRIVE, 3, 0, 0);
		push_item(CMD_ARRIVE, 2, 31, 63);
		push_item(CMD_ARRIVE, 1, 12, 30);
		push_item(CMD_ARRIVE, 0, 23, 59);
		push_item(CMD_SERVE, 0, 23, 59);
		push_item(CMD_SERVE, 1, 12, 15);
		push_item(CMD_SERVE, 2, 0, 0);
		push_item(CMD_SERVE, 3, 23, 59);
		push_item(CMD_SERVE, 0, 10, 10);
		for (c = 0; c < NUM_CLASSES; c++)
			push_item(CMD_QUERY, c, 5, 5);
		push_item(CMD_ARRIVE, 1, 24, 60);
		push_item(CMD_SERVE, 1, 5, 59);
		push_item(CMD_UNUSED, 2, 16, 32);
		push_drain();

		// Random part: mostly structured floods, drains and mixed traffic.
		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			seg = $urandom_range(0, 19);
			if (random_count > RANDOM_ITEMS / 2 && n_drains == 0 && seg == 0)
				seg = 19;
			if (seg < 11) begin
				n = $urandom_range(5, 25);
				for (k = 0; k < n; k++) begin
					c = $urandom_range(0, 19);
					cls = $urandom_range(0, 3);
					if (c < 9)
						push_item(CMD_ARRIVE, cls, rand_hour(), rand_minute());
					else if (c < 16)
						push_item(CMD_SERVE, cls, rand_hour(), rand_minute());
					else if (c < 19)
						push_item(CMD_QUERY, cls, rand_hour(), rand_minute());
					else
						push_item(CMD_UNUSED, cls, rand_hour(), rand_minute());
				end
			end else if (seg < 14) begin
				// Flood one class so that its queue can fill and arrivals can drop.
				n = $urandom_range(12, 20);
				cls = $urandom_range(0, 3);
				for (k = 0; k < n; k++)
					push_item(CMD_ARRIVE, cls, rand_hour(), rand_minute());
			end else if (seg < 17) begin
				n = $urandom_range(6, 30);
				for (k = 0; k < n; k++)
					push_item(CMD_SERVE, $urandom_range(0, 3), rand_hour(), rand_minute());
			end else if (seg < 19) begin
				n = $urandom_range(3, 10);
				for (k = 0; k < n; k++)
					push_item(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 3),
						$urandom_range(0, 31), $urandom_range(0, 63));
			end else begin
				n = 0;
				push_drain();
			end
			random_count += n;
			if (random_count >= RANDOM_ITEMS / 2 && random_count - n < RANDOM_ITEMS / 2)
				push_drain();
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		spin = 0;
		while (report_fifo.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		repeat (10) @(posedge clk);
		if (report_fifo.size() != 0) begin
			fail_count++;
			$display("%0d expected results never arrived", report_fifo.size());
		end

		$display("Run: %0d items, %0d results, %0d served, %0d empty serves, %0d drops.",
			items_taken, results_seen, n_served, n_empty_serves, n_dropped);
		$display("Peak occupancy %0d, longest wait %0d min, %0d input drains, %0d long stalls.",
			peak_seen, longest_seen, n_drains, holds_done);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
